FILE: rtl/assert_macros.svh
// assertion helpers, included by the top-level writer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expression holds at every enabled clock edge
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/ppmw_pkg.sv
`default_nettype none

package ppmw_pkg;

    localparam int unsigned MAX_DIMENSION = 4096;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // register indexes on the config port
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_LIMIT   = 2'd2;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // one classified component, handed from front to back
    typedef struct packed {
        logic        header;
        logic [12:0] width;
        logic [1:0]  width_nd;
        logic [12:0] height;
        logic [1:0]  height_nd;
        logic [7:0]  value;
        logic [1:0]  value_nd;
        logic        sep_nl;
        logic        row_nl;
        logic        last_row;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic idle;
    } back_status_t;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0)
            r = 13'd1;
        else if (v > 13'(MAX_DIMENSION))
            r = 13'(MAX_DIMENSION);
        else
            r = v;
        return r;
    endfunction

    // number of decimal digits minus one
    function automatic logic [1:0] digits_m1(input logic [12:0] v);
        logic [1:0] r;
        if (v >= 13'd1000)
            r = 2'd3;
        else if (v >= 13'd100)
            r = 2'd2;
        else if (v >= 13'd10)
            r = 2'd1;
        else
            r = 2'd0;
        return r;
    endfunction

    function automatic logic [13:0] digit_place(input logic [1:0] idx);
        logic [13:0] r;
        unique case (idx)
            2'd3:    r = 14'd1000;
            2'd2:    r = 14'd100;
            2'd1:    r = 14'd10;
            default: r = 14'd1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ppmw_front.sv
`default_nettype none

module ppmw_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [15:0]   component_value,
    input  wire logic [12:0]          image_width,
    input  wire logic [12:0]          image_height,
    input  wire logic [7:0]           line_limit,
    input  wire ppmw_pkg::queue_status_t queue_status,
    output logic                      push,
    output ppmw_pkg::cmd_t            cmd
);

    logic [7:0]  line_length_reg, line_length_next;
    logic [13:0] comp_in_row_reg, comp_in_row_next;
    logic [11:0] row_index_reg, row_index_next;
    logic        header_sent_reg, header_sent_next;

    logic [12:0] width_c;
    logic [12:0] height_c;
    logic        positive;
    logic [22:0] product;
    logic [10:0] scaled;
    logic [7:0]  value;
    logic [1:0]  value_nd;
    logic [8:0]  wrap_sum;
    logic        sep_nl;
    logic [13:0] comp_inc;
    logic [14:0] three_w;
    logic        row_end;
    logic [11:0] row_inc;
    logic        last_row;

    assign in_ready = !queue_status.full;
    assign push     = in_valid && !queue_status.full;

    assign width_c  = ppmw_pkg::clamp_dim(image_width);
    assign height_c = ppmw_pkg::clamp_dim(image_height);

    // value * 255 / 4096, as (v << 8) - v
    assign positive = !component_value[15] && (component_value != 16'sd0);
    assign product  = {component_value[14:0], 8'b0} - {8'b0, component_value[14:0]};
    assign scaled   = product[22:12];
    assign value    = !positive ? 8'd0 : ((|scaled[10:8]) ? 8'd255 : scaled[7:0]);
    assign value_nd = ppmw_pkg::digits_m1({5'b0, value});

    assign wrap_sum = {1'b0, line_length_reg} + 9'd8;
    assign sep_nl   = !(wrap_sum < {1'b0, line_limit});

    assign comp_inc = comp_in_row_reg + 14'd1;
    assign three_w  = {2'b0, width_c} + {1'b0, width_c, 1'b0};
    assign row_end  = {1'b0, comp_inc} >= three_w;
    assign row_inc  = row_index_reg + 12'd1;
    assign last_row = ({1'b0, row_inc} >= height_c) || (row_inc == 12'd0);

    always_comb
    begin
        cmd.header    = !header_sent_reg;
        cmd.width     = width_c;
        cmd.width_nd  = ppmw_pkg::digits_m1(width_c);
        cmd.height    = height_c;
        cmd.height_nd = ppmw_pkg::digits_m1(height_c);
        cmd.value     = value;
        cmd.value_nd  = value_nd;
        cmd.sep_nl    = sep_nl;
        cmd.row_nl    = row_end;
        cmd.last_row  = row_end && last_row;
    end

    always_comb
    begin
        line_length_next = line_length_reg;
        comp_in_row_next = comp_in_row_reg;
        row_index_next   = row_index_reg;
        header_sent_next = header_sent_reg;
        if (push)
        begin
            header_sent_next = 1'b1;
            if (sep_nl)
                line_length_next = 8'd0;
            else
                line_length_next = line_length_reg + {6'b0, value_nd} + 8'd2;
            comp_in_row_next = comp_inc;
            if (row_end)
            begin
                comp_in_row_next = 14'd0;
                line_length_next = 8'd0;
                row_index_next   = row_inc;
                if (last_row)
                begin
                    row_index_next   = 12'd0;
                    header_sent_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= 8'd0;
            comp_in_row_reg <= 14'd0;
            row_index_reg   <= 12'd0;
            header_sent_reg <= 1'b0;
        end
        else
        begin
            line_length_reg <= line_length_next;
            comp_in_row_reg <= comp_in_row_next;
            row_index_reg   <= row_index_next;
            header_sent_reg <= header_sent_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ppmw_cmd_fifo.sv
`default_nettype none

module ppmw_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ppmw_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output ppmw_pkg::cmd_t      head_cmd,
    output ppmw_pkg::queue_status_t status
);

    localparam int unsigned AW = ppmw_pkg::QUEUE_AW;

    ppmw_pkg::cmd_t entries_reg [ppmw_pkg::QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (AW+1)'(ppmw_pkg::QUEUE_DEPTH));
    assign head_cmd     = entries_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ppmw_back.sv
`default_nettype none

module ppmw_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ppmw_pkg::cmd_t head_cmd,
    input  wire ppmw_pkg::queue_status_t queue_status,
    output logic                pop,
    output ppmw_pkg::back_status_t back_status,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          text_byte,
    output logic                last_of_run,
    output logic                image_end
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_P     = 4'd1;
    localparam logic [3:0] ST_3     = 4'd2;
    localparam logic [3:0] ST_NL1   = 4'd3;
    localparam logic [3:0] ST_WNUM  = 4'd4;
    localparam logic [3:0] ST_SP    = 4'd5;
    localparam logic [3:0] ST_HNUM  = 4'd6;
    localparam logic [3:0] ST_NL2   = 4'd7;
    localparam logic [3:0] ST_2     = 4'd8;
    localparam logic [3:0] ST_5A    = 4'd9;
    localparam logic [3:0] ST_5B    = 4'd10;
    localparam logic [3:0] ST_NL3   = 4'd11;
    localparam logic [3:0] ST_VNUM  = 4'd12;
    localparam logic [3:0] ST_SEP   = 4'd13;
    localparam logic [3:0] ST_ROWNL = 4'd14;

    logic [3:0]     state_reg, state_next;
    ppmw_pkg::cmd_t cmd_reg, cmd_next;
    logic [12:0]    rem_reg, rem_next;
    logic [1:0]     idx_reg, idx_next;

    logic           out_valid_reg, out_valid_next;
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic           end_reg, end_next;

    logic           advance;
    logic           emit;
    logic           done;
    logic [7:0]     emit_byte;
    logic           emit_end;
    logic [13:0]    place;
    logic [3:0]     digit;
    logic [13:0]    sub;
    logic [3:0]     start_state;
    logic [12:0]    start_rem;
    logic [1:0]     start_idx;

    assign advance          = !out_valid_reg || out_ready;
    assign back_status.idle = (state_reg == ST_IDLE);

    assign out_valid   = out_valid_reg;
    assign text_byte   = byte_reg;
    assign last_of_run = last_reg;
    assign image_end   = end_reg;

    // where a freshly popped word begins
    assign start_state = head_cmd.header ? ST_P : ST_VNUM;
    assign start_rem   = {5'b0, head_cmd.value};
    assign start_idx   = head_cmd.value_nd;

    // one decimal digit per cycle unless stalled, by parallel compares against k * place
    always_comb
    begin
        place = ppmw_pkg::digit_place(idx_reg);
        digit = 4'd0;
        sub   = 14'd0;
        for (int k = 1; k < 10; k++)
        begin
            if ({1'b0, rem_reg} >= 14'(k) * place)
            begin
                digit = 4'(k);
                sub   = 14'(k) * place;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        emit       = 1'b0;
        done       = 1'b0;
        emit_byte  = ppmw_pkg::CH_SPACE;
        emit_end   = 1'b0;
        pop        = 1'b0;

        if (state_reg == ST_IDLE)
        begin
            if (!queue_status.empty)
            begin
                pop        = 1'b1;
                cmd_next   = head_cmd;
                state_next = start_state;
                rem_next   = start_rem;
                idx_next   = start_idx;
            end
        end
        else if (advance)
        begin
            emit = 1'b1;
            unique case (state_reg)
                ST_P:
                begin
                    emit_byte  = ppmw_pkg::CH_P;
                    state_next = ST_3;
                end
                ST_3:
                begin
                    emit_byte  = ppmw_pkg::CH_3;
                    state_next = ST_NL1;
                end
                ST_NL1:
                begin
                    emit_byte  = ppmw_pkg::CH_NL;
                    state_next = ST_WNUM;
                    rem_next   = cmd_reg.width;
                    idx_next   = cmd_reg.width_nd;
                end
                ST_WNUM, ST_HNUM, ST_VNUM:
                begin
                    emit_byte = ppmw_pkg::CH_ZERO | {4'b0, digit};
                    rem_next  = rem_reg - sub[12:0];
                    idx_next  = idx_reg - 2'd1;
                    if (idx_reg == 2'd0)
                    begin
                        unique case (state_reg)
                            ST_WNUM: state_next = ST_SP;
                            ST_HNUM: state_next = ST_NL2;
                            default: state_next = ST_SEP;
                        endcase
                    end
                end
                ST_SP:
                begin
                    emit_byte  = ppmw_pkg::CH_SPACE;
                    state_next = ST_HNUM;
                    rem_next   = cmd_reg.height;
                    idx_next   = cmd_reg.height_nd;
                end
                ST_NL2:
                begin
                    emit_byte  = ppmw_pkg::CH_NL;
                    state_next = ST_2;
                end
                ST_2:
                begin
                    emit_byte  = ppmw_pkg::CH_2;
                    state_next = ST_5A;
                end
                ST_5A:
                begin
                    emit_byte  = ppmw_pkg::CH_5;
                    state_next = ST_5B;
                end
                ST_5B:
                begin
                    emit_byte  = ppmw_pkg::CH_5;
                    state_next = ST_NL3;
                end
                ST_NL3:
                begin
                    emit_byte  = ppmw_pkg::CH_NL;
                    state_next = ST_VNUM;
                    rem_next   = {5'b0, cmd_reg.value};
                    idx_next   = cmd_reg.value_nd;
                end
                ST_SEP:
                begin
                    emit_byte = cmd_reg.sep_nl ? ppmw_pkg::CH_NL : ppmw_pkg::CH_SPACE;
                    if (cmd_reg.row_nl)
                        state_next = ST_ROWNL;
                    else
                        done = 1'b1;
                end
                ST_ROWNL:
                begin
                    emit_byte = ppmw_pkg::CH_NL;
                    emit_end  = cmd_reg.last_row;
                    done      = 1'b1;
                end
                default:
                begin
                    emit       = 1'b0;
                    state_next = ST_IDLE;
                end
            endcase

            // chain straight into the next word so no bubble is left
            if (done)
            begin
                if (!queue_status.empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head_cmd;
                    state_next = start_state;
                    rem_next   = start_rem;
                    idx_next   = start_idx;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        byte_next      = byte_reg;
        last_next      = last_reg;
        end_next       = end_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            byte_next      = emit_byte;
            last_next      = done;
            end_next       = emit_end;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        rem_reg  <= rem_next;
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        end_reg  <= end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ppm_ascii_pixel_writer.sv
// words pass the queue, the back-end command register and the output byte register
// throughput: one output byte per cycle unless out_ready stalls; a component takes 2 to 5
// bytes (digits, separator, row newline), plus 11 to 17 bytes for an image header
// the byte sequencer in the back end sets the rate; a 4-entry queue decouples input
// reset: asynchronous active low, clears counters, queue and output; header due
`default_nettype none
`include "assert_macros.svh"

module ppm_ascii_pixel_writer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [12:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] component_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              text_byte,
    output logic                    last_of_run,
    output logic                    image_end
);

    logic [12:0] image_width_reg, image_width_next;
    logic [12:0] image_height_reg, image_height_next;
    logic [7:0]  line_limit_reg, line_limit_next;

    ppmw_pkg::cmd_t          push_cmd;
    ppmw_pkg::cmd_t          head_cmd;
    ppmw_pkg::queue_status_t queue_status;
    ppmw_pkg::back_status_t  back_status;
    logic                    push;
    logic                    pop;

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        line_limit_next   = line_limit_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                ppmw_pkg::CFG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                ppmw_pkg::CFG_IMAGE_HEIGHT: image_height_next = cfg_data;
                ppmw_pkg::CFG_LINE_LIMIT:   line_limit_next   = cfg_data[7:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 13'd1;
            image_height_reg <= 13'd1;
            line_limit_reg   <= 8'd70;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            line_limit_reg   <= line_limit_next;
        end
    end

    ppmw_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .component_value (component_value),
        .image_width     (image_width_reg),
        .image_height    (image_height_reg),
        .line_limit      (line_limit_reg),
        .queue_status    (queue_status),
        .push            (push),
        .cmd             (push_cmd)
    );

    ppmw_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (queue_status)
    );

    ppmw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .queue_status (queue_status),
        .pop          (pop),
        .back_status  (back_status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .text_byte    (text_byte),
        .last_of_run  (last_of_run),
        .image_end    (image_end)
    );

    // image end only ever rides on the closing row newline
    `ASSERT_SAME(a_end_on_last, clk, rst_n, out_valid && image_end,
                 last_of_run && (text_byte == ppmw_pkg::CH_NL))
    // an idle back end picks up a waiting word at once
    `ASSERT_NEXT(a_idle_pops, clk, rst_n, back_status.idle && !queue_status.empty, !back_status.idle)
    `ASSERT_ALWAYS(a_queue_flags, clk, rst_n, !(queue_status.empty && queue_status.full))

endmodule

`default_nettype wire

FILE: test/tb_ppm_ascii_pixel_writer.sv
module tb_ppm_ascii_pixel_writer;

    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         MAX_REPORTS = 10;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       img_end;
    } text_char_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [12:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] component_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         text_byte;
    logic               last_of_run;
    logic               image_end;

    // predictor copy of the registers and counters
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [7:0]  limit_reg;
    logic [7:0]  line_len;
    logic [13:0] comp_cnt;
    logic [11:0] row_cnt;
    bit          hdr_done;

    text_char_t text_expected[$];
    text_char_t run_chars[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    int  hold_cycles = 0;
    bit  no_idle = 1'b0;

    ppm_ascii_pixel_writer i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .component_value (component_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .text_byte       (text_byte),
        .last_of_run     (last_of_run),
        .image_end       (image_end)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic add_char(input logic [7:0] ch, input logic img_end);
        text_char_t c;
        c.ch = ch;
        c.last = 1'b0;
        c.img_end = img_end;
        run_chars.push_back(c);
    endtask

    task automatic add_decimal(input int unsigned v, output int unsigned n);
        int unsigned div;
        int unsigned d;
        bit          started;
        div = 1000;
        n = 0;
        started = 1'b0;
        if (v > 9999)
            v = 9999;
        while (div > 0)
        begin
            d = (v / div) % 10;
            if (started || d != 0 || div == 1)
            begin
                add_char(ppmw_pkg::CH_ZERO + 8'(d), 1'b0);
                started = 1'b1;
                n++;
            end
            div = div / 10;
        end
    endtask

    function automatic int unsigned bounded_dim(input logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > ppmw_pkg::MAX_DIMENSION)
            return ppmw_pkg::MAX_DIMENSION;
        return v;
    endfunction

    // text produced by one component, queued as expected bytes
    task automatic predict_component(input logic signed [15:0] value);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned scaled;
        bit          last_row;
        w = bounded_dim(width_reg);
        h = bounded_dim(height_reg);
        run_chars.delete();
        if (!hdr_done)
        begin
            add_char(ppmw_pkg::CH_P, 1'b0);
            add_char(ppmw_pkg::CH_3, 1'b0);
            add_char(ppmw_pkg::CH_NL, 1'b0);
            add_decimal(w, n);
            add_char(ppmw_pkg::CH_SPACE, 1'b0);
            add_decimal(h, n);
            add_char(ppmw_pkg::CH_NL, 1'b0);
            add_char(ppmw_pkg::CH_2, 1'b0);
            add_char(ppmw_pkg::CH_5, 1'b0);
            add_char(ppmw_pkg::CH_5, 1'b0);
            add_char(ppmw_pkg::CH_NL, 1'b0);
            hdr_done = 1'b1;
        end
        if (value <= 0)
            scaled = 0;
        else
            scaled = (int'(value) * 255) >> 12;
        if (scaled > 255)
            scaled = 255;
        add_decimal(scaled, n);
        if (int'(line_len) + 8 < int'(limit_reg))
        begin
            add_char(ppmw_pkg::CH_SPACE, 1'b0);
            line_len = 8'(int'(line_len) + n + 1);
        end
        else
        begin
            add_char(ppmw_pkg::CH_NL, 1'b0);
            line_len = '0;
        end
        comp_cnt = comp_cnt + 14'd1;
        if (int'(comp_cnt) >= 3 * w)
        begin
            comp_cnt = '0;
            line_len = '0;
            row_cnt = row_cnt + 12'd1;
            last_row = (int'(row_cnt) >= h) || (row_cnt == 0);
            add_char(ppmw_pkg::CH_NL, last_row);
            if (last_row)
            begin
                row_cnt = '0;
                hdr_done = 1'b0;
            end
        end
        run_chars[run_chars.size() - 1].last = 1'b1;
        foreach (run_chars[i])
            text_expected.push_back(run_chars[i]);
    endtask

    task automatic flag_mismatch(input string what, input text_char_t want);
        if (mismatches < MAX_REPORTS)
            $display("cycle %0d: %s: expected %h/%b/%b got %h/%b/%b", cycle_count, what,
                     want.ch, want.last, want.img_end, text_byte, last_of_run, image_end);
        mismatches++;
    endtask

    // receiver: checks every accepted byte against the oldest expectation
    initial
    begin
        int         stall;
        text_char_t want;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (text_expected.size() == 0)
                begin
                    want = '{8'h00, 1'b0, 1'b0};
                    flag_mismatch("unexpected byte", want);
                end
                else
                begin
                    want = text_expected.pop_front();
                    if (text_byte !== want.ch || last_of_run !== want.last ||
                        image_end !== want.img_end)
                        flag_mismatch("byte mismatch", want);
                end
                stall = no_idle ? 0 : $urandom_range(9, 0);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 13'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            ppmw_pkg::CFG_IMAGE_WIDTH:  width_reg = 13'(value);
            ppmw_pkg::CFG_IMAGE_HEIGHT: height_reg = 13'(value);
            ppmw_pkg::CFG_LINE_LIMIT:   limit_reg = 8'(value);
            default:                    ;
        endcase
    endtask

    task automatic set_image(input int unsigned w, input int unsigned h, input int unsigned lim);
        write_reg(ppmw_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(ppmw_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(ppmw_pkg::CFG_LINE_LIMIT, lim);
    endtask

    // valid stays high into the next word when no gap is drawn
    task automatic send_word(input logic signed [15:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(9, 0);
        if (gap > 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        component_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        predict_component(v);
        items_sent++;
    endtask

    task automatic wait_drained();
        if (in_valid)
            in_valid <= 1'b0;
        while (text_expected.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic signed [15:0] random_component();
        case ($urandom_range(3, 0))
            0, 1:    return 16'($urandom());
            2:       return 16'($urandom_range(4200, 0));
            default: return 16'($urandom_range(200, 0));
        endcase
    endfunction

    // one 2x2 image through every digit count, the clip points and negatives
    task automatic test_value_extremes();
        logic signed [15:0] vals[12];
        vals = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sd17, 16'sd161,
                 16'sd1606, 16'sd1622, 16'sd4095, 16'sd4096, 16'sd4113, 16'sd32767};
        set_image(2, 2, 70);
        foreach (vals[i])
            send_word(vals[i]);
        wait_drained();
    endtask

    // zero and oversize dimensions, then shrinking the bounds mid-image
    task automatic test_dimension_bounds();
        set_image(0, 0, 255);
        repeat (3) send_word(random_component());
        wait_drained();
        set_image(8191, 8191, 255);
        write_reg(CFG_UNUSED, 13'h1FFF);
        repeat (3) send_word(random_component());
        wait_drained();
        write_reg(ppmw_pkg::CFG_IMAGE_WIDTH, 1);
        send_word(16'sd4096);
        wait_drained();
        write_reg(ppmw_pkg::CFG_IMAGE_HEIGHT, 1);
        repeat (2) send_word(random_component());
        wait_drained();
    endtask

    // limits at or below eight put a newline after every component
    task automatic test_short_lines();
        set_image(2, 1, 8);
        repeat (6) send_word(random_component());
        wait_drained();
        set_image(1, 1, 0);
        repeat (3) send_word(random_component());
        wait_drained();
    endtask

    task automatic test_random_images();
        int unsigned w;
        int unsigned h;
        int unsigned lim;
        int unsigned count;
        int          target;
        target = items_sent + 40;
        while (items_sent < target)
        begin
            w = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
            h = $urandom_range(3, 1);
            case ($urandom_range(3, 0))
                0:       lim = 16;
                1:       lim = 255;
                default: lim = $urandom_range(255, 0);
            endcase
            no_idle = ($urandom_range(4, 0) == 0);
            set_image(w, h, lim);
            count = 3 * w * h;
            // sometimes stop mid-image so the next settings land on a partial row
            if ($urandom_range(4, 0) == 0)
                count = $urandom_range(3 * w * h, 1);
            if (int'(count) > target - items_sent)
                count = target - items_sent;
            repeat (count) send_word(random_component());
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while words keep coming, so the input stalls
    task automatic test_output_stall();
        set_image(3, 2, 40);
        hold_cycles = 150;
        no_idle = 1'b1;
        repeat (18) send_word(random_component());
        no_idle = 1'b0;
        wait_drained();
    endtask

    // sender goes quiet mid-image until all text is out, settings untouched
    task automatic test_sender_pause();
        set_image(3, 2, 30);
        repeat (3)
        begin
            repeat (6) send_word(random_component());
            wait_drained();
        end
    endtask

    initial
    begin
        width_reg = 13'd1;
        height_reg = 13'd1;
        limit_reg = 8'd70;
        line_len = '0;
        comp_cnt = '0;
        row_cnt = '0;
        hdr_done = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_value_extremes();
        test_dimension_bounds();
        test_short_lines();
        test_random_images();
        test_output_stall();
        test_sender_pause();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && text_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
